// ===== rtl/window_convolution_2d_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef WINDOW_CONVOLUTION_2D_TOP_ASSERT_SVH
`define WINDOW_CONVOLUTION_2D_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define WC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define WC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wc2d_pkg.sv =====
package wc2d_pkg;

   localparam int MaxWidth  = 1024;
   localparam int Channels  = 3;
   localparam int MaxRadius = 2;
   localparam int Win       = 2 * MaxRadius + 1;
   localparam int Lines     = 2 * MaxRadius;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int ChW       = 2;
   localparam int RowW      = 3;
   localparam int AddrW     = $clog2(MaxWidth * Channels);
   localparam int TapW      = 3;
   localparam int SumW      = 32;

   // Register indexes.
   localparam logic [2:0] RegWidth  = 3'd0;
   localparam logic [2:0] RegRadius = 3'd1;
   localparam logic [2:0] RegScale  = 3'd2;
   localparam logic [2:0] RegCoef0  = 3'd3;

   // Controller to datapath commands.
   typedef struct packed {
      logic             take;      // latch sample, read line stores
      logic             shift;     // update lines and window
      logic             clear_acc;
      logic             mac;       // one tap step
      logic             scale;     // multiply by scale
      logic             finish;    // truncate and load output
      logic [TapW-1:0]  tap_row;   // kernel row of the current tap
      logic [TapW-1:0]  tap_col;   // kernel column of the current tap
   } cmd_type;

   typedef struct packed {
      logic emit;       // current sample yields a result
      logic out_full;
   } stat_type;

endpackage

// ===== rtl/wc2d_datapath.sv =====
module wc2d_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  wc2d_pkg::cmd_type        cmd,
   output wc2d_pkg::stat_type       stat,
   input  logic [7:0]               pixel_sample,
   input  logic                     frame_start,
   input  logic                     csr_valid,
   input  logic [2:0]               csr_index,
   input  logic [59:0]              csr_data,
   output logic                     out_valid,
   input  logic                     out_take,
   output logic [31:0]              out_value,
   output logic [1:0]               out_channel,
   output logic                     out_last
);
   import wc2d_pkg::*;

   logic [10:0] width_ff;
   logic [1:0]  radius_ff;
   logic [17:0] scale_ff;
   logic [59:0] coef_ff [Win];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         radius_ff <= 2'd1;
         scale_ff  <= 18'd65536;
         for (int i = 0; i < Win; i++) coef_ff[i] <= '0;
      end else if (csr_valid) begin
         if (csr_index == RegWidth) width_ff <= csr_data[10:0];
         else if (csr_index == RegRadius) radius_ff <= csr_data[1:0];
         else if (csr_index == RegScale) scale_ff <= csr_data[17:0];
         else if (csr_index >= RegCoef0)
            coef_ff[csr_index - RegCoef0] <= csr_data;
      end
   end

   // Effective width and radius.
   logic [10:0] width_eff;
   logic [2:0]  span;
   always_comb begin
      width_eff = width_ff;
      if (width_ff == 11'd0) width_eff = 11'd1;
      else if (width_ff > 11'(MaxWidth)) width_eff = 11'(MaxWidth);
      span = (radius_ff >= 2'd2) ? 3'd4 : 3'd2;
   end

   // Counters.
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic [ChW-1:0]  ch_ff, ch_in;
   logic [ColW-1:0] cur_col;
   logic [RowW-1:0] cur_row;
   logic [ChW-1:0]  cur_ch;
   logic [ChW-1:0]  s_ch_ff;
   logic [7:0]      s_pix_ff;
   logic            s_emit_ff, s_last_ff;

   always_comb begin
      cur_col = frame_start ? '0 : col_ff;
      cur_row = frame_start ? '0 : row_ff;
      cur_ch  = frame_start ? '0 : ch_ff;
      col_in = cur_col; row_in = cur_row; ch_in = cur_ch;
      if (32'(cur_ch) + 1 >= Channels) begin
         ch_in = '0;
         if (32'(cur_col) + 1 >= 32'(width_eff)) begin
            col_in = '0;
            if (cur_row < RowW'(Lines)) row_in = cur_row + 1'b1;
         end else col_in = cur_col + 1'b1;
      end else ch_in = cur_ch + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; ch_ff <= '0;
      end else if (cmd.take) begin
         col_ff <= col_in; row_ff <= row_in; ch_ff <= ch_in;
      end
   end

   // Sample stage.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         s_ch_ff   <= cur_ch;
         s_pix_ff  <= pixel_sample;
         s_emit_ff <= (cur_row >= span) && (cur_col >= ColW'(span));
         s_last_ff <= (32'(cur_col) + 1 >= 32'(width_eff)) &&
                      (32'(cur_ch) + 1 >= Channels);
      end
   end
   assign stat.emit = s_emit_ff;

   // Line stores, one memory per line, read registered.
   logic [AddrW-1:0] rd_addr, wr_addr_ff;
   logic [7:0] line_q_ff [Lines];
   logic [7:0] mem [Lines][MaxWidth*Channels];
   assign rd_addr = AddrW'(32'(cur_col) * Channels + 32'(cur_ch));

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         wr_addr_ff <= rd_addr;
         for (int l = 0; l < Lines; l++) line_q_ff[l] <= mem[l][rd_addr];
      end
      if (cmd.shift) begin
         for (int l = 0; l < Lines - 1; l++) mem[l][wr_addr_ff] <= line_q_ff[l+1];
         mem[Lines-1][wr_addr_ff] <= s_pix_ff;
      end
   end

   // Window registers per channel.
   logic [7:0] win_ff [Channels][Win][Win];
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int r = 0; r < Win; r++) begin
            for (int c = 0; c < Win - 1; c++)
               win_ff[s_ch_ff][r][c] <= win_ff[s_ch_ff][r][c+1];
            win_ff[s_ch_ff][r][Win-1] <= (r == Lines) ? s_pix_ff : line_q_ff[r];
         end
      end
   end

   // One tap per cycle over the active window.
   logic [2:0] tr, tc, base;
   logic signed [11:0] coef;
   logic [7:0] tpix;
   logic signed [20:0] tap_prod;
   logic signed [SumW-1:0] acc_ff;
   logic signed [49:0] prod_ff;
   always_comb begin
      tr       = cmd.tap_row;
      tc       = cmd.tap_col;
      base     = 3'(Lines) - span;
      coef     = coef_ff[tr][12*tc +: 12];
      tpix     = win_ff[s_ch_ff][base + tr][base + tc];
      tap_prod = coef * $signed({1'b0, tpix});
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_acc) acc_ff <= '0;
      else if (cmd.mac && tr <= span && tc <= span)
         acc_ff <= acc_ff + SumW'(tap_prod);
      if (cmd.scale) prod_ff <= 50'(acc_ff) * 50'($signed(scale_ff));
   end

   // Truncate toward zero and hold in the output register.
   logic [49:0] mag;
   logic [31:0] res;
   always_comb begin
      mag = prod_ff[49] ? 50'(-prod_ff) : 50'(prod_ff);
      res = prod_ff[49] ? 32'(-(mag >> 16)) : 32'(mag >> 16);
   end

   logic out_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.finish) out_valid_ff <= 1'b1;
      else if (out_take) out_valid_ff <= 1'b0;
      if (cmd.finish) begin
         out_value   <= res;
         out_channel <= s_ch_ff;
         out_last    <= s_last_ff;
      end
   end
   assign out_valid     = out_valid_ff;
   assign stat.out_full = out_valid_ff && !out_take;
endmodule

// ===== rtl/wc2d_ctrl.sv =====
module wc2d_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_fire,
   output logic               in_ready,
   input  wc2d_pkg::stat_type stat,
   output wc2d_pkg::cmd_type  cmd
);
   import wc2d_pkg::*;

   localparam logic [2:0] SIdle  = 3'd0;
   localparam logic [2:0] SShift = 3'd1;
   localparam logic [2:0] SMac   = 3'd2;
   localparam logic [2:0] SScale = 3'd3;
   localparam logic [2:0] SWait  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [TapW-1:0] tap_row_ff, tap_row_in;
   logic [TapW-1:0] tap_col_ff, tap_col_in;

   // Sequencer: shift, then, if the sample yields a result, tap loop, scale, deliver.
   always_comb begin
      state_in    = state_ff;
      tap_row_in  = tap_row_ff;
      tap_col_in  = tap_col_ff;
      cmd         = '0;
      cmd.tap_row = tap_row_ff;
      cmd.tap_col = tap_col_ff;
      in_ready    = (state_ff == SIdle);
      unique case (state_ff)
         SIdle: if (in_fire) begin
            cmd.take = 1'b1; state_in = SShift;
         end
         SShift: begin
            cmd.shift = 1'b1; cmd.clear_acc = 1'b1;
            tap_row_in = '0; tap_col_in = '0;
            state_in = stat.emit ? SMac : SIdle;
         end
         SMac: begin
            cmd.mac = 1'b1;
            // Walk the window row by row, column by column.
            if (tap_col_ff == TapW'(Win - 1)) begin
               tap_col_in = '0;
               tap_row_in = tap_row_ff + 1'b1;
               if (tap_row_ff == TapW'(Win - 1)) state_in = SScale;
            end else tap_col_in = tap_col_ff + 1'b1;
         end
         SScale: begin
            cmd.scale = 1'b1; state_in = SWait;
         end
         SWait: if (!stat.out_full) begin
            cmd.finish = 1'b1; state_in = SIdle;
         end
         default: state_in = SIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIdle; tap_row_ff <= '0; tap_col_ff <= '0;
      end else begin
         state_ff <= state_in; tap_row_ff <= tap_row_in; tap_col_ff <= tap_col_in;
      end
   end
endmodule

// ===== rtl/window_convolution_2d_top.sv =====
// Channel | Direction | Contents
// req     | in        | tdata[7:0] pixel_sample, tuser frame_start
// rsp     | out       | tdata[31:0] filtered_value, tuser[1:0] channel_index, tlast row_last
// csr     | in        | index 0..7, data up to 60 bits
// A sample with a result is processed by the single multiply-accumulate unit,
// which walks all 25 taps one per cycle, then a scale multiply and a truncate
// step; no new sample is taken until the block is through with the last one.
// Reset is synchronous, clears counters and control and loads the default configuration.
// A held output stalls the sequencer before the result register is reloaded.
module window_convolution_2d_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel_sample
   input  logic        req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // filtered_value
   output logic [1:0]  rsp_tuser,   // channel_index
   output logic        rsp_tlast,   // row_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [59:0] csr_data
);
   import wc2d_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   // Controller.
   wc2d_ctrl u_ctrl (
      .clock, .reset,
      .in_fire (req_tvalid && req_tready),
      .in_ready(req_tready),
      .stat, .cmd
   );

   // Datapath.
   wc2d_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .pixel_sample(req_tdata),
      .frame_start (req_tuser),
      .csr_valid, .csr_index, .csr_data,
      .out_valid  (rsp_tvalid),
      .out_take   (rsp_tready),
      .out_value  (rsp_tdata),
      .out_channel(rsp_tuser),
      .out_last   (rsp_tlast)
   );
endmodule

// ===== rtl/wc2d_checker.sv =====
`include "window_convolution_2d_top_assert.svh"
module wc2d_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);
   // A result waiting to be taken stays.
   `WC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped")
   // Channel index stays within the channel count.
   `WC_ASSERT_IMPL(a_ch_range, clock, reset, rsp_tvalid, rsp_tuser != 2'd3, "bad channel")
   // Row end only on the last channel.
   `WC_ASSERT_IMPL(a_last_ch, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == 2'd2, "row end channel")
   // Request taken means no request taken next cycle.
   `WC_ASSERT_NEXT(a_seq, clock, reset, req_tvalid && req_tready, !req_tready, "back to back take")
endmodule

bind window_convolution_2d_top wc2d_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready,
   .rsp_tvalid, .rsp_tready, .rsp_tuser, .rsp_tlast
);

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wc2d_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int ItemGoal   = 1550;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  channel;
      logic        row_end;
   } conv_result_type;

   // Model of the filter: line stores, window, counters and registers.
   class conv_scoreboard;
      logic [7:0]   lines[Lines][MaxWidth][Channels];
      logic [7:0]   window[Channels][Win][Win];
      int unsigned  column_count, row_count, channel_count;
      logic [59:0]  regs[8];
      conv_result_type expected_q[$];
      int           failures;

      function new();
         foreach (regs[i]) regs[i] = '0;
         regs[RegWidth]  = 60'd1024;
         regs[RegRadius] = 60'd1;
         regs[RegScale]  = 60'd65536;
         column_count = 0;
         row_count = 0;
         channel_count = 0;
         failures = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [59:0] data);
         case (index)
            RegWidth:  regs[index] = data & 60'h7FF;
            RegRadius: regs[index] = data & 60'h3;
            RegScale:  regs[index] = data & 60'h3FFFF;
            default:   regs[index] = data;
         endcase
      endfunction

      // Takes one accepted sample and queues the result it produces, if any.
      function void note_sample(logic [7:0] pix, logic frame_start);
         int unsigned  w, rad, ch, col, span, base;
         logic [7:0]   column[Win];
         logic [11:0]  bits;
         longint       sum, scl, prod;
         conv_result_type r;
         w = regs[RegWidth][10:0];
         if (w == 0) w = 1;
         if (w > MaxWidth) w = MaxWidth;
         rad = regs[RegRadius][1:0];
         if (rad == 0) rad = 1;
         if (rad > MaxRadius) rad = MaxRadius;
         if (frame_start) begin
            column_count = 0;
            row_count = 0;
            channel_count = 0;
         end
         ch = channel_count;
         col = column_count;

         // Push the new column down through the line stores.
         for (int l = 0; l < Lines; l++) column[l] = lines[l][col][ch];
         column[Lines] = pix;
         for (int l = 0; l < Lines; l++) lines[l][col][ch] = column[l + 1];
         for (int y = 0; y < Win; y++) begin
            for (int x = 0; x + 1 < Win; x++) window[ch][y][x] = window[ch][y][x + 1];
            window[ch][y][Win - 1] = column[y];
         end

         span = 2 * rad;
         if (row_count >= span && col >= span) begin
            sum = 0;
            base = (Win - 1) - span;
            for (int y = 0; y <= span; y++)
               for (int x = 0; x <= span; x++) begin
                  bits = regs[RegCoef0 + y][12 * x +: 12];
                  sum += longint'($signed(bits)) * longint'(window[ch][base + y][base + x]);
               end
            scl = longint'($signed(regs[RegScale][17:0]));
            prod = sum * scl;
            if (prod < 0) r.value = 32'(-((-prod) >> 16));
            else r.value = 32'(prod >> 16);
            r.channel = 2'(ch);
            r.row_end = (col + 1 >= w) && (ch + 1 >= Channels);
            expected_q.push_back(r);
         end

         // Advance the raster position.
         if (ch + 1 >= Channels) begin
            channel_count = 0;
            if (col + 1 >= w) begin
               column_count = 0;
               if (row_count < Lines) row_count++;
            end else begin
               column_count = col + 1;
            end
         end else begin
            channel_count = ch + 1;
         end
      endfunction

      function void check(logic [31:0] value, logic [1:0] channel, logic row_end);
         conv_result_type e;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: value %0d", $signed(value));
            failures++;
            return;
         end
         e = expected_q.pop_front();
         if (value !== e.value) begin
            $error("filtered_value: expected %0d, actual %0d", $signed(e.value), $signed(value));
            failures++;
         end
         if (channel !== e.channel) begin
            $error("channel_index: expected %0d, actual %0d", e.channel, channel);
            failures++;
         end
         if (row_end !== e.row_end) begin
            $error("row_last: expected %0d, actual %0d", e.row_end, row_end);
            failures++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [59:0] csr_data;

   conv_scoreboard board = new();
   int          cycles = 0;
   int          samples_sent = 0;
   int          results_seen = 0;
   bit          calm = 0;

   window_convolution_2d_top DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check(rsp_tdata, rsp_tuser, rsp_tlast);
         results_seen++;
      end
   end

   // Receiver: random stalls, one long hold-off after the first results.
   initial begin
      int hold;
      bit held;
      hold = 0;
      held = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && results_seen >= 20) begin
            held = 1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 21);
         end
      end
   end

   // Leaves the write channel valid; the caller drops it after the last write.
   task automatic write_csr(logic [2:0] index, logic [59:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(index, data);
   endtask

   task automatic send_sample(logic [7:0] pix, logic frame_start);
      while (!calm && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= frame_start;
      do @(posedge clock); while (!req_tready);
      board.note_sample(pix, frame_start);
      samples_sent++;
   endtask

   // Waits for the block to drain, then rewrites every register.
   task automatic configure(logic [10:0] width, logic [1:0] radius, logic [17:0] scale,
                            logic [59:0] k0, logic [59:0] k1, logic [59:0] k2,
                            logic [59:0] k3, logic [59:0] k4);
      req_tvalid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      write_csr(RegWidth, 60'(width));
      write_csr(RegRadius, 60'(radius));
      write_csr(RegScale, 60'(scale));
      write_csr(RegCoef0, k0);
      write_csr(RegCoef0 + 3'd1, k1);
      write_csr(RegCoef0 + 3'd2, k2);
      write_csr(RegCoef0 + 3'd3, k3);
      write_csr(RegCoef0 + 3'd4, k4);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [59:0] random_coefs();
      return 60'({$urandom, $urandom});
   endfunction

   function automatic logic [7:0] random_pixel();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // One image of the given size; if noisy, a few stray frame starts act as noise.
   task automatic send_frame(int width, int rows, bit noisy);
      for (int y = 0; y < rows; y++)
         for (int x = 0; x < width; x++)
            for (int c = 0; c < Channels; c++)
               send_sample(random_pixel(),
                           (y == 0 && x == 0 && c == 0) ||
                           (noisy && $urandom_range(199) == 0));
   endtask

   initial begin
      logic [10:0] w;
      logic [1:0]  rad;
      logic [17:0] scl;
      int          eff_w, eff_r, phase;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme coefficients, pixels and scales on images five pixels wide.
      configure(11'd5, 2'd1, 18'd65536, {5{12'h7FF}}, {5{12'h800}}, {5{12'h7FF}},
                '0, '0);
      for (int i = 0; i < 45; i++)
         send_sample(i[0] ? 8'hFF : 8'h00, i == 0);
      configure(11'd5, 2'd2, 18'h20000, {5{12'h800}}, {5{12'h800}}, {5{12'h800}},
                {5{12'h800}}, {5{12'h800}});
      send_frame(5, 5, 0);
      configure(11'd5, 2'd2, 18'h1FFFF, {5{12'h7FF}}, {5{12'h7FF}}, {5{12'h7FF}},
                {5{12'h7FF}}, {5{12'h7FF}});
      send_frame(5, 5, 0);

      // Width extremes: zero acts as one, the top of the field saturates.
      configure(11'd0, 2'd0, 18'd65536, '1, '1, '1, '1, '1);
      send_frame(1, 6, 0);
      configure(11'h7FF, 2'd3, 18'd65536, '1, '1, '1, '1, '1);
      for (int i = 0; i < 30; i++) send_sample(random_pixel(), i == 0);
      configure(11'd1024, 2'd1, 18'd65536, '1, '1, '1, '1, '1);
      for (int i = 0; i < 30; i++) send_sample(random_pixel(), i == 0);

      // Random phases over small images.
      phase = 0;
      while (samples_sent < ItemGoal) begin
         w = 11'($urandom_range(5, 10));
         if ($urandom_range(9) == 0) w = 11'($urandom_range(1, 4));
         rad = 2'($urandom_range(3));
         case ($urandom_range(5))
            0: scl = 18'h20000;
            1: scl = 18'h1FFFF;
            2: scl = 18'd65536;
            default: scl = 18'($urandom);
         endcase
         configure(w, rad, scl, random_coefs(), random_coefs(), random_coefs(),
                   random_coefs(), random_coefs());
         eff_w = w;
         eff_r = (rad == 0) ? 1 : (rad > MaxRadius ? MaxRadius : rad);
         calm = (phase >= 4 && phase < 7);
         for (int f = 0; f < $urandom_range(1, 2); f++)
            send_frame(eff_w, 2 * eff_r + $urandom_range(1, 2), 1);
         calm = 0;
         phase++;
      end
      req_tvalid <= 1'b0;

      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.failures == 0 && board.expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
